FILE: hw/rtl/lss_pkg.sv
`timescale 1ns / 1ps
// Package for the LIFO stack with search: depth, derived widths, operation
// and status codes, and the command struct shared by controller and datapath.
// No dependencies.
package lss_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] OP_PUSH          = 3'd0;
    localparam logic [FUNC_W-1:0] OP_POP           = 3'd1;
    localparam logic [FUNC_W-1:0] OP_PEEK          = 3'd2;
    localparam logic [FUNC_W-1:0] OP_SEARCH        = 3'd3;
    localparam logic [FUNC_W-1:0] OP_INSERT_BOTTOM = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    localparam logic [VALUE_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [POS_W-1:0]   NOT_FOUND     = 5'h1F;

    typedef struct packed {
        logic              exec;
        logic [FUNC_W-1:0] func;
    } t_cmd;

endpackage

FILE: hw/rtl/lss_ctrl.sv
`timescale 1ns / 1ps
// Controller of the LIFO stack: beat handshakes and the result-held state.
// Depends on lss_pkg.
module lss_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic [lss_pkg::FUNC_W-1:0]     i_func,
    input  logic                           i_m_tready,
    output logic                           o_s_tready,
    output logic                           o_m_tvalid,
    output lss_pkg::t_cmd                  o_cmd
);
    import lss_pkg::*;

    localparam logic S_EMPTY = 1'b0;
    localparam logic S_HOLD  = 1'b1;

    logic r_state;
    logic n_state;
    logic take;

    assign o_s_tready = (r_state == S_EMPTY) || i_m_tready;
    assign take       = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == S_HOLD);

    assign o_cmd.exec = take;
    assign o_cmd.func = i_func;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_EMPTY: begin
                if (take) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (take)            n_state = S_HOLD;
                else if (i_m_tready) n_state = S_EMPTY;
            end
            default: n_state = S_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_EMPTY;
        else          r_state <= n_state;
    end

endmodule

FILE: hw/rtl/lss_dp.sv
`timescale 1ns / 1ps
// Datapath of the LIFO stack: entry registers (top at index 0), held count,
// parallel search compare and the result register. Depends on lss_pkg.
module lss_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lss_pkg::t_cmd                  i_cmd,
    input  logic [lss_pkg::VALUE_W-1:0]    i_value,
    output logic [lss_pkg::VALUE_W-1:0]    o_read_value,
    output logic [lss_pkg::POS_W-1:0]      o_position,
    output logic                           o_is_empty,
    output logic [lss_pkg::POS_W-1:0]      o_entry_count,
    output logic [lss_pkg::STATUS_W-1:0]   o_status
);
    import lss_pkg::*;

    logic [VALUE_W-1:0]  r_stack [STACK_DEPTH];
    logic [VALUE_W-1:0]  n_stack [STACK_DEPTH];
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic [VALUE_W-1:0]  r_rd;
    logic [POS_W-1:0]    r_pos;
    logic                r_empty;
    logic [POS_W-1:0]    r_cnt_out;
    logic [STATUS_W-1:0] r_st;

    logic [VALUE_W-1:0]  n_rd;
    logic [POS_W-1:0]    n_pos;
    logic [STATUS_W-1:0] n_st;

    logic                full;
    logic                empty;
    logic [STACK_DEPTH-1:0] hit;
    logic                found;
    logic [IDX_W-1:0]    hit_idx;
    logic [31:0]         hit_ext;
    logic [31:0]         cnt_ext;

    assign full  = (r_count == CNT_W'(STACK_DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        for (int j = 0; j < STACK_DEPTH; j++) begin
            hit[j] = (CNT_W'(j) < r_count) && (r_stack[j] == i_value);
        end
    end

    // nearest match to the top wins
    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int j = STACK_DEPTH - 1; j >= 0; j--) begin
            if (hit[j]) begin
                found   = 1'b1;
                hit_idx = IDX_W'(j);
            end
        end
    end

    assign hit_ext = 32'(hit_idx);

    always_comb begin
        n_stack = r_stack;
        n_count = r_count;
        n_rd    = '0;
        n_pos   = '0;
        n_st    = ST_OK;
        case (i_cmd.func)
            OP_PUSH: begin
                if (full) begin
                    n_st = ST_OVERFLOW;
                end else begin
                    n_stack[0] = i_value;
                    for (int j = 1; j < STACK_DEPTH; j++) n_stack[j] = r_stack[j-1];
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (empty) begin
                    n_rd = MOST_NEGATIVE;
                    n_st = ST_UNDERFLOW;
                end else begin
                    n_rd = r_stack[0];
                    for (int j = 0; j < STACK_DEPTH - 1; j++) n_stack[j] = r_stack[j+1];
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_PEEK: begin
                if (empty) begin
                    n_rd = MOST_NEGATIVE;
                    n_st = ST_UNDERFLOW;
                end else begin
                    n_rd = r_stack[0];
                end
            end
            OP_SEARCH: begin
                n_pos = found ? hit_ext[POS_W-1:0] : NOT_FOUND;
            end
            OP_INSERT_BOTTOM: begin
                if (full) begin
                    n_st = ST_OVERFLOW;
                end else begin
                    for (int j = 0; j < STACK_DEPTH; j++) begin
                        if (CNT_W'(j) == r_count) n_stack[j] = i_value;
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign cnt_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_stack   <= n_stack;
            r_rd      <= n_rd;
            r_pos     <= n_pos;
            r_empty   <= (n_count == '0);
            r_cnt_out <= cnt_ext[POS_W-1:0];
            r_st      <= n_st;
        end
    end

    assign o_read_value  = r_rd;
    assign o_position    = r_pos;
    assign o_is_empty    = r_empty;
    assign o_entry_count = r_cnt_out;
    assign o_status      = r_st;

endmodule

FILE: hw/rtl/lifo_stack_with_search.sv
`timescale 1ns / 1ps
// Top level of the LIFO stack with search: beat ports, controller and datapath.
// Depends on lss_pkg, lss_ctrl and lss_dp.
//
// A 16-entry stack of signed 32-bit words held in flip-flops. Each input beat
// carries an operation and a value and yields exactly one result beat in the
// next cycle; push and pop shift the entry registers, search compares all
// entries in parallel. One beat per cycle is sustained: the result register
// is freed in the same cycle it is taken, so a new beat is accepted whenever
// no result is held or the held one is being read. No clearing pass after reset.
module lifo_stack_with_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lss_pkg::S_TDATA_W-1:0]     s_tdata,   // [2:0] func, [34:3] value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lss_pkg::M_TDATA_W-1:0]     m_tdata    // [31:0] read_value,
                                                         // [36:32] position,
                                                         // [37] is_empty,
                                                         // [42:38] entry_count,
                                                         // [44:43] status
);
    import lss_pkg::*;

    t_cmd                cmd;
    logic [VALUE_W-1:0]  read_value;
    logic [POS_W-1:0]    position;
    logic                is_empty;
    logic [POS_W-1:0]    entry_count;
    logic [STATUS_W-1:0] status;

    lss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_func     (s_tdata[FUNC_W-1:0]),
        .i_m_tready (m_tready),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .o_cmd      (cmd)
    );

    lss_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_value       (s_tdata[FUNC_W +: VALUE_W]),
        .o_read_value  (read_value),
        .o_position    (position),
        .o_is_empty    (is_empty),
        .o_entry_count (entry_count),
        .o_status      (status)
    );

    assign m_tdata = {3'b000, status, entry_count, is_empty, position, read_value};

endmodule

FILE: hw/rtl/lss_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the LIFO stack with search, bound to the top level.
// Depends on lss_pkg and lifo_stack_with_search.
module lss_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lss_pkg::M_TDATA_W-1:0]     m_tdata
);
    import lss_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result held");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat gave no result");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[37] == (m_tdata[42:38] == 5'd0)))
        else $error("empty flag disagrees with count");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[44:43] == ST_OVERFLOW) |->
            (m_tdata[42:38] == 5'(STACK_DEPTH)))
        else $error("overflow reported below full");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/tb_lifo_stack_with_search.sv
`timescale 1ns / 1ps
// Self-checking bench for lifo_stack_with_search: directed table, then random
// op sequences, each result checked against a typed row or in-bench stack model.
// Depends on lss_pkg and the lifo_stack_with_search RTL.
module tb_lifo_stack_with_search;

    import lss_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [4:0]          entry_count;
        logic                is_empty;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  read_value;
    } t_result;

    localparam logic [VALUE_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [FUNC_W-1:0]  OP_NOP5 = 3'd5;
    localparam logic [FUNC_W-1:0]  OP_NOP6 = 3'd6;
    localparam logic [FUNC_W-1:0]  OP_NOP7 = 3'd7;
    localparam int                 RANDOM_BEATS = 900;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [2:0] func, [34:3] value
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [31:0] read_value, [36:32] position,
                                     // [37] is_empty, [42:38] entry_count,
                                     // [44:43] status

    lifo_stack_with_search i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // stack model
    logic [VALUE_W-1:0] model_words [STACK_DEPTH];
    int                 model_depth;

    t_result            pending_results [$];
    int                 mismatch_count;
    int                 burst_left;
    int                 ready_left;
    int                 ready_mode;
    logic [15:0]        ready_pattern;
    t_result            got_res;
    t_result            want_res;

    logic [FUNC_W-1:0]  row_func [$];
    logic [VALUE_W-1:0] row_value [$];
    int                 row_reps [$];
    bit                 row_typed [$];
    t_result            row_want [$];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_result stack_apply(input logic [FUNC_W-1:0] f,
                                            input logic [VALUE_W-1:0] v);
        t_result r;
        int      i;
        bit      found;
        r = '0;
        found = 1'b0;
        case (f)
            OP_PUSH: begin
                if (model_depth >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    model_words[model_depth] = v;
                    model_depth++;
                end
            end
            OP_POP: begin
                if (model_depth == 0) begin
                    r.read_value = MOST_NEGATIVE;
                    r.status     = ST_UNDERFLOW;
                end else begin
                    model_depth--;
                    r.read_value = model_words[model_depth];
                end
            end
            OP_PEEK: begin
                if (model_depth == 0) begin
                    r.read_value = MOST_NEGATIVE;
                    r.status     = ST_UNDERFLOW;
                end else begin
                    r.read_value = model_words[model_depth-1];
                end
            end
            OP_SEARCH: begin
                r.position = NOT_FOUND;
                for (i = 0; i < model_depth; i++) begin
                    if (!found && model_words[model_depth-1-i] == v) begin
                        r.position = i[POS_W-1:0];
                        found      = 1'b1;
                    end
                end
            end
            OP_INSERT_BOTTOM: begin
                if (model_depth >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    for (i = model_depth; i > 0; i--)
                        model_words[i] = model_words[i-1];
                    model_words[0] = v;
                    model_depth++;
                end
            end
            default: ;
        endcase
        r.is_empty    = (model_depth == 0);
        r.entry_count = model_depth[4:0];
        return r;
    endfunction

    function automatic t_result mk_res(input logic [STATUS_W-1:0] st, input int cnt,
                                       input logic [POS_W-1:0] pos,
                                       input logic [VALUE_W-1:0] rd);
        t_result r;
        r.status      = st;
        r.entry_count = cnt[4:0];
        r.is_empty    = (cnt == 0);
        r.position    = pos;
        r.read_value  = rd;
        return r;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                           input int reps, input bit typed, input t_result want);
        row_func.push_back(f);
        row_value.push_back(v);
        row_reps.push_back(reps);
        row_typed.push_back(typed);
        row_want.push_back(want);
    endtask

    task automatic report(input string what, input logic [VALUE_W-1:0] got,
                          input logic [VALUE_W-1:0] want);
        if (mismatch_count < 40)
            $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                             input bit typed, input t_result want);
        int      gap;
        t_result r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, v, f};
        do @(posedge i_clk); while (!s_tready);
        r = stack_apply(f, v);
        pending_results.push_back(typed ? want : r);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(16, 80);
        end
        ready_left--;
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ready_pattern[0];
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result beat", m_tdata[31:0], '0);
            end else begin
                want_res = pending_results.pop_front();
                got_res  = m_tdata[44:0];
                if (got_res.read_value != want_res.read_value)
                    report("read_value", got_res.read_value, want_res.read_value);
                if (got_res.position != want_res.position)
                    report("position", 32'(got_res.position), 32'(want_res.position));
                if (got_res.is_empty != want_res.is_empty)
                    report("is_empty", 32'(got_res.is_empty), 32'(want_res.is_empty));
                if (got_res.entry_count != want_res.entry_count)
                    report("entry_count", 32'(got_res.entry_count),
                           32'(want_res.entry_count));
                if (got_res.status != want_res.status)
                    report("status", 32'(got_res.status), 32'(want_res.status));
            end
        end
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [VALUE_W-1:0] pool [8];
        logic [FUNC_W-1:0]  f;
        logic [VALUE_W-1:0] v;
        int                 n;
        int                 k;
        int                 r;
        int                 grow;
        int                 seg_left;

        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        model_depth    = 0;
        mismatch_count = 0;
        burst_left     = 0;
        ready_left     = 0;
        ready_mode     = 0;
        ready_pattern  = 16'b1101_0011_1010_0110;
        seg_left       = 0;
        grow           = 50;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty, unused op codes, fill to full, overflow, deep search, final pop
        add_row(OP_POP,    32'd0, 1, 1, mk_res(ST_UNDERFLOW, 0, '0, MOST_NEGATIVE));
        add_row(OP_PEEK,   32'd0, 1, 1, mk_res(ST_UNDERFLOW, 0, '0, MOST_NEGATIVE));
        add_row(OP_SEARCH, 32'd0, 1, 1, mk_res(ST_OK, 0, NOT_FOUND, '0));
        add_row(OP_NOP7,   32'hFFFF_FFFF, 1, 1, mk_res(ST_OK, 0, '0, '0));
        add_row(OP_PUSH,   INT_MAX, 1, 1, mk_res(ST_OK, 1, '0, '0));
        add_row(OP_PUSH,   MOST_NEGATIVE, 1, 1, mk_res(ST_OK, 2, '0, '0));
        add_row(OP_PEEK,   32'd0, 1, 1, mk_res(ST_OK, 2, '0, MOST_NEGATIVE));
        add_row(OP_INSERT_BOTTOM, 32'hFFFF_FFFF, 1, 1, mk_res(ST_OK, 3, '0, '0));
        add_row(OP_SEARCH, INT_MAX, 1, 0, '0);
        add_row(OP_PUSH,   32'hAAAA_AAAA, 6, 0, '0);
        add_row(OP_PUSH,   32'h5555_5555, 7, 0, '0);
        add_row(OP_PUSH,   32'd1, 1, 1, mk_res(ST_OVERFLOW, 16, '0, '0));
        add_row(OP_INSERT_BOTTOM, 32'd1, 1, 1, mk_res(ST_OVERFLOW, 16, '0, '0));
        add_row(OP_SEARCH, 32'hFFFF_FFFF, 1, 0, '0);
        add_row(OP_SEARCH, 32'hAAAA_AAAA, 1, 0, '0);
        add_row(OP_NOP5,   32'h1234_5678, 1, 0, '0);
        add_row(OP_NOP6,   32'h8765_4321, 1, 0, '0);
        add_row(OP_POP,    32'd0, 1, 0, '0);

        for (n = 0; n < row_func.size(); n++)
            for (k = 0; k < row_reps[n]; k++)
                send_beat(row_func[n], row_value[n], row_typed[n], row_want[n]);

        pool[0] = MOST_NEGATIVE;
        pool[1] = INT_MAX;
        pool[2] = 32'd0;
        pool[3] = 32'hFFFF_FFFF;
        for (k = 4; k < 8; k++)
            pool[k] = $urandom;

        for (n = 0; n < RANDOM_BEATS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0:       grow = 85;
                    1:       grow = 15;
                    default: grow = 50;
                endcase
                pool[$urandom_range(4, 7)] = $urandom;
            end
            seg_left--;

            r = $urandom_range(0, 99);
            if (r < 4)
                f = FUNC_W'($urandom_range(OP_NOP5, OP_NOP7));
            else if (r < 18)
                f = OP_SEARCH;
            else if (r < 26)
                f = OP_PEEK;
            else if ($urandom_range(0, 99) < grow)
                f = ($urandom_range(0, 3) == 0) ? OP_INSERT_BOTTOM : OP_PUSH;
            else
                f = OP_POP;

            r = $urandom_range(0, 9);
            if (f == OP_SEARCH && model_depth > 0 && r < 6)
                v = model_words[$urandom_range(0, model_depth - 1)];
            else if (r < 5)
                v = pool[$urandom_range(0, 7)];
            else
                v = $urandom;

            send_beat(f, v, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: lifo_stack_with_search.f
hw/rtl/lss_pkg.sv
hw/rtl/lss_ctrl.sv
hw/rtl/lss_dp.sv
hw/rtl/lifo_stack_with_search.sv
hw/rtl/lss_checker.sv
tb/sv/tb_lifo_stack_with_search.sv
